// ----- hdl/two_level_cache_hit_miss_model_defines.svh -----
// ----------------------------------------------------------------------------
// Two-level cache model assertion macros
// Property wrappers used by the checker file tlc_checker.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_CACHE_HIT_MISS_MODEL_DEFINES_SVH
`define TWO_LEVEL_CACHE_HIT_MISS_MODEL_DEFINES_SVH

// same-cycle implication, masked during reset
`define TLC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlc same-cycle check failed");

// next-cycle implication, masked during reset
`define TLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlc next-cycle check failed");

`endif

// ----- hdl/tlc_pkg.sv -----
// ----------------------------------------------------------------------------
// tlc_pkg
// Shared types, codes and address helpers of the two-level cache model.
// ----------------------------------------------------------------------------
package tlc_pkg;

    localparam int SET_W  = 16;
    localparam int RAW_W  = 15;
    localparam int CFG_DW = 5;
    localparam int CFG_AW = 3;
    localparam int Q_DEPTH = 2;

    typedef enum logic [2:0] {
        ST_NONE  = 3'd0,
        ST_RHIT  = 3'd1,
        ST_RMISS = 3'd2,
        ST_WHIT  = 3'd3,
        ST_WMISS = 3'd4
    } t_status;

    localparam logic [CFG_AW-1:0] REG_L1_OFF  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_L1_IDX  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_L1_WAYS = 3'd2;
    localparam logic [CFG_AW-1:0] REG_L2_OFF  = 3'd3;
    localparam logic [CFG_AW-1:0] REG_L2_IDX  = 3'd4;
    localparam logic [CFG_AW-1:0] REG_L2_WAYS = 3'd5;

    typedef struct packed {
        logic [4:0] l1_off;
        logic [3:0] l1_idx;
        logic [3:0] l1_ways;
        logic [4:0] l2_off;
        logic [3:0] l2_idx;
        logic [4:0] l2_ways;
    } t_cfg;

    typedef struct packed {
        logic             op;
        logic [31:0]      t1;
        logic [SET_W-1:0] s1;
        logic [31:0]      t2;
        logic [SET_W-1:0] s2;
    } t_req;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [31:0] addr_tag(input logic [31:0] a, input logic [4:0] off,
                                             input logic [3:0] idx);
        logic [5:0] sh;
        sh = 6'(off) + 6'(idx);
        return (sh >= 6'd32) ? 32'd0 : (a >> sh);
    endfunction

    function automatic logic [RAW_W-1:0] addr_raw_set(input logic [31:0] a,
                                                      input logic [4:0] off,
                                                      input logic [3:0] idx);
        logic [31:0]      sh;
        logic [RAW_W-1:0] mask;
        sh   = a >> off;
        mask = RAW_W'((32'd1 << idx) - 32'd1);
        return sh[RAW_W-1:0] & mask;
    endfunction

endpackage

// ----- hdl/tlc_queue.sv -----
// ----------------------------------------------------------------------------
// tlc_queue
// Two-entry request queue between the address-split front and the lookup back.
// ----------------------------------------------------------------------------
module tlc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tlc_pkg::t_req   i_req,
    input  logic            i_pop,
    output tlc_pkg::t_req   o_head,
    output tlc_pkg::t_q_stat o_stat
);
    import tlc_pkg::*;

    t_req       r_mem [Q_DEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_req;
    end

    assign o_head       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == 2'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == 2'd0);
endmodule

// ----- hdl/tlc_front.sv -----
// ----------------------------------------------------------------------------
// tlc_front
// Accept an access, split the address for both levels, reduce set numbers.
// ----------------------------------------------------------------------------
module tlc_front #(
    parameter int L1_MAX_SETS = 256,
    parameter int L2_MAX_SETS = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tlc_pkg::t_cfg    i_cfg,
    input  logic             i_hold,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_operation,
    input  logic [31:0]      i_address,
    output logic             o_push,
    output tlc_pkg::t_req    o_req,
    input  tlc_pkg::t_q_stat i_q_stat
);
    import tlc_pkg::*;

    localparam logic [32:0] L1_RECIP = 33'((64'd1 << 32) / L1_MAX_SETS);
    localparam logic [32:0] L2_RECIP = 33'((64'd1 << 32) / L2_MAX_SETS);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_MUL  = 3'b010,
        F_PUSH = 3'b100
    } t_fr_state;

    t_fr_state        r_state, n_state;
    logic             r_op;
    logic [31:0]      r_t1, r_t2;
    logic [RAW_W-1:0] r_v1, r_v2, r_q1, r_q2;
    logic             w_accept;
    logic [47:0]      w_p1, w_p2;
    logic [31:0]      w_r1, w_r2, w_s1, w_s2;

    always_comb begin
        o_push     = (r_state == F_PUSH) && !i_q_stat.full;
        o_in_stall = i_hold || !((r_state == F_IDLE) || o_push);
        w_accept   = i_in_valid && !o_in_stall;
        w_p1 = 48'(r_v1) * 48'(L1_RECIP);
        w_p2 = 48'(r_v2) * 48'(L2_RECIP);
        w_r1 = 32'(r_v1) - 32'(r_q1) * 32'(L1_MAX_SETS);
        w_r2 = 32'(r_v2) - 32'(r_q2) * 32'(L2_MAX_SETS);
        w_s1 = (w_r1 >= 32'(L1_MAX_SETS)) ? w_r1 - 32'(L1_MAX_SETS) : w_r1;
        w_s2 = (w_r2 >= 32'(L2_MAX_SETS)) ? w_r2 - 32'(L2_MAX_SETS) : w_r2;
        o_req.op = r_op;
        o_req.t1 = r_t1;
        o_req.s1 = w_s1[SET_W-1:0];
        o_req.t2 = r_t2;
        o_req.s2 = w_s2[SET_W-1:0];
        n_state = r_state;
        case (r_state)
            F_IDLE:  if (w_accept) n_state = F_MUL;
            F_MUL:   n_state = F_PUSH;
            F_PUSH:  if (w_accept) n_state = F_MUL;
                     else if (o_push) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= F_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op <= i_operation;
            r_t1 <= addr_tag(i_address, i_cfg.l1_off, i_cfg.l1_idx);
            r_t2 <= addr_tag(i_address, i_cfg.l2_off, i_cfg.l2_idx);
            r_v1 <= addr_raw_set(i_address, i_cfg.l1_off, i_cfg.l1_idx);
            r_v2 <= addr_raw_set(i_address, i_cfg.l2_off, i_cfg.l2_idx);
        end
        if (r_state == F_MUL) begin
            r_q1 <= w_p1[32+RAW_W-1:32];
            r_q2 <= w_p2[32+RAW_W-1:32];
        end
    end
endmodule

// ----- hdl/tlc_back.sv -----
// ----------------------------------------------------------------------------
// tlc_back
// Clear the valid rows after reset, look up both tag stores, classify the access, fill on read misses.
// ----------------------------------------------------------------------------
module tlc_back #(
    parameter int L1_MAX_WAYS = 8,
    parameter int L1_MAX_SETS = 256,
    parameter int L2_MAX_WAYS = 16,
    parameter int L2_MAX_SETS = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tlc_pkg::t_cfg    i_cfg,
    input  tlc_pkg::t_req    i_head,
    input  tlc_pkg::t_q_stat i_q_stat,
    output logic             o_pop,
    output logic             o_clearing,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [2:0]       o_l1_status,
    output logic [2:0]       o_l2_status
);
    import tlc_pkg::*;

    localparam int L1_SW = (L1_MAX_SETS > 1) ? $clog2(L1_MAX_SETS) : 1;
    localparam int L2_SW = (L2_MAX_SETS > 1) ? $clog2(L2_MAX_SETS) : 1;
    localparam int L1_WW = (L1_MAX_WAYS > 1) ? $clog2(L1_MAX_WAYS) : 1;
    localparam int L2_WW = (L2_MAX_WAYS > 1) ? $clog2(L2_MAX_WAYS) : 1;
    localparam int L1_WC = $clog2(L1_MAX_WAYS + 1);
    localparam int L2_WC = $clog2(L2_MAX_WAYS + 1);
    localparam int CLR_N = (L1_MAX_SETS > L2_MAX_SETS) ? L1_MAX_SETS : L2_MAX_SETS;
    localparam int CW    = (CLR_N > 1) ? $clog2(CLR_N) : 1;
    localparam int L1_MW = L1_MAX_WAYS + L1_WW;
    localparam int L2_MW = L2_MAX_WAYS + L2_WW;

    typedef enum logic [2:0] {
        S_CLR  = 3'b001,
        S_LOOK = 3'b010,
        S_CMP  = 3'b100
    } t_bk_state;

    logic [L1_MAX_WAYS*32-1:0] r_l1_tag_mem [L1_MAX_SETS];
    logic [L2_MAX_WAYS*32-1:0] r_l2_tag_mem [L2_MAX_SETS];
    logic [L1_MW-1:0]          r_l1_meta_mem [L1_MAX_SETS];
    logic [L2_MW-1:0]          r_l2_meta_mem [L2_MAX_SETS];
    logic [L1_MAX_WAYS*32-1:0] r_l1_tag_q;
    logic [L2_MAX_WAYS*32-1:0] r_l2_tag_q;
    logic [L1_MW-1:0]          r_l1_meta_q;
    logic [L2_MW-1:0]          r_l2_meta_q;

    t_bk_state     r_state, n_state;
    logic [CW-1:0] r_cnt;
    t_req          r_req;
    logic          r_out_vld;
    t_status       r_st1, r_st2, w_st1, w_st2;

    logic             w_fin, w_h1, w_h2, w_fill1, w_fill2, w_clr1, w_clr2;
    logic [L1_WC-1:0] w_w1, w_p1c, w_p1n;
    logic [L2_WC-1:0] w_w2, w_p2c, w_p2n;
    logic [L1_WW-1:0] w_p1;
    logic [L2_WW-1:0] w_p2;
    logic [L1_MW-1:0] w_meta1;
    logic [L2_MW-1:0] w_meta2;
    logic [L1_SW-1:0] w_a1;
    logic [L2_SW-1:0] w_a2;

    always_comb begin
        o_pop = (r_state == S_LOOK) && !i_q_stat.empty;
        w_fin = (r_state == S_CMP) && (!r_out_vld || !i_out_stall);
        w_a1  = r_req.s1[L1_SW-1:0];
        w_a2  = r_req.s2[L2_SW-1:0];
        w_clr1 = (r_state == S_CLR) && ({1'b0, r_cnt} < (CW+1)'(L1_MAX_SETS));
        w_clr2 = (r_state == S_CLR) && ({1'b0, r_cnt} < (CW+1)'(L2_MAX_SETS));

        if (i_cfg.l1_ways == 4'd0)                     w_w1 = L1_WC'(1);
        else if ({3'b0, i_cfg.l1_ways} > 7'(L1_MAX_WAYS)) w_w1 = L1_WC'(L1_MAX_WAYS);
        else                                           w_w1 = L1_WC'(i_cfg.l1_ways);
        if (i_cfg.l2_ways == 5'd0)                     w_w2 = L2_WC'(1);
        else if ({2'b0, i_cfg.l2_ways} > 7'(L2_MAX_WAYS)) w_w2 = L2_WC'(L2_MAX_WAYS);
        else                                           w_w2 = L2_WC'(i_cfg.l2_ways);

        w_h1 = 1'b0;
        for (int i = 0; i < L1_MAX_WAYS; i++) begin
            if (r_l1_meta_q[i] && (r_l1_tag_q[i*32 +: 32] == r_req.t1)
                && (L1_WC'(i) < w_w1)) w_h1 = 1'b1;
        end
        w_h2 = 1'b0;
        for (int i = 0; i < L2_MAX_WAYS; i++) begin
            if (r_l2_meta_q[i] && (r_l2_tag_q[i*32 +: 32] == r_req.t2)
                && (L2_WC'(i) < w_w2)) w_h2 = 1'b1;
        end

        w_p1c = L1_WC'(r_l1_meta_q[L1_MW-1:L1_MAX_WAYS]);
        if (w_p1c >= w_w1) w_p1c = '0;
        w_p1  = w_p1c[L1_WW-1:0];
        w_p1n = w_p1c + L1_WC'(1);
        if (w_p1n >= w_w1) w_p1n = '0;
        w_meta1 = r_l1_meta_q;
        w_meta1[w_p1] = 1'b1;
        w_meta1[L1_MW-1:L1_MAX_WAYS] = w_p1n[L1_WW-1:0];

        w_p2c = L2_WC'(r_l2_meta_q[L2_MW-1:L2_MAX_WAYS]);
        if (w_p2c >= w_w2) w_p2c = '0;
        w_p2  = w_p2c[L2_WW-1:0];
        w_p2n = w_p2c + L2_WC'(1);
        if (w_p2n >= w_w2) w_p2n = '0;
        w_meta2 = r_l2_meta_q;
        w_meta2[w_p2] = 1'b1;
        w_meta2[L2_MW-1:L2_MAX_WAYS] = w_p2n[L2_WW-1:0];

        w_fill1 = 1'b0;
        w_fill2 = 1'b0;
        if (w_h1) begin
            w_st1 = r_req.op ? ST_WHIT : ST_RHIT;
            w_st2 = ST_NONE;
        end else if (r_req.op) begin
            w_st1 = ST_WMISS;
            w_st2 = w_h2 ? ST_WHIT : ST_WMISS;
        end else begin
            w_st1   = ST_RMISS;
            w_st2   = w_h2 ? ST_RHIT : ST_RMISS;
            w_fill1 = w_fin;
            w_fill2 = w_fin && !w_h2;
        end

        n_state = r_state;
        case (r_state)
            S_CLR:   if (r_cnt == CW'(CLR_N - 1)) n_state = S_LOOK;
            S_LOOK:  if (o_pop) n_state = S_CMP;
            S_CMP:   if (w_fin) n_state = S_LOOK;
            default: n_state = S_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) r_cnt <= r_cnt + CW'(1);
            if (w_fin)            r_out_vld <= 1'b1;
            else if (!i_out_stall) r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_req <= i_head;
        if (w_fin) begin
            r_st1 <= w_st1;
            r_st2 <= w_st2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fill1) r_l1_tag_mem[w_a1][w_p1*32 +: 32] <= r_req.t1;
        if (o_pop)   r_l1_tag_q <= r_l1_tag_mem[i_head.s1[L1_SW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_fill2) r_l2_tag_mem[w_a2][w_p2*32 +: 32] <= r_req.t2;
        if (o_pop)   r_l2_tag_q <= r_l2_tag_mem[i_head.s2[L2_SW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_clr1)       r_l1_meta_mem[r_cnt[L1_SW-1:0]] <= '0;
        else if (w_fill1) r_l1_meta_mem[w_a1] <= w_meta1;
        if (o_pop)        r_l1_meta_q <= r_l1_meta_mem[i_head.s1[L1_SW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_clr2)       r_l2_meta_mem[r_cnt[L2_SW-1:0]] <= '0;
        else if (w_fill2) r_l2_meta_mem[w_a2] <= w_meta2;
        if (o_pop)        r_l2_meta_q <= r_l2_meta_mem[i_head.s2[L2_SW-1:0]];
    end

    assign o_clearing  = (r_state == S_CLR);
    assign o_out_valid = r_out_vld;
    assign o_l1_status = r_st1;
    assign o_l2_status = r_st2;
endmodule

// ----- hdl/two_level_cache_hit_miss_model.sv -----
// ----------------------------------------------------------------------------
// two_level_cache_hit_miss_model
// Two-level set-associative hit/miss model with round-robin read fills.
// ----------------------------------------------------------------------------
//  channel | handshake                 | payload
//  --------+---------------------------+----------------------------------
//  in      | i_in_valid / o_in_stall   | i_operation, i_address
//  out     | o_out_valid / i_out_stall | o_l1_status, o_l2_status
//  cfg     | i_cfg_we                  | i_cfg_index, i_cfg_data
//
//  Front: split on accept, reciprocal set reduction in F_MUL, push in
//  F_PUSH; it can take a new access while it pushes the last one.
//  Back: tag/valid row read in S_LOOK, then compare and fill in S_CMP;
//  it pops the next request only once the last one has finished.
//  After reset a clearing pass over max(L1_MAX_SETS, L2_MAX_SETS) rows
//  wipes the valid rows; o_in_stall stays high meanwhile.
//  Either side may stall; the two-entry queue and output register hold.
// ----------------------------------------------------------------------------
module two_level_cache_hit_miss_model #(
    parameter int L1_MAX_WAYS = 8,
    parameter int L1_MAX_SETS = 256,
    parameter int L2_MAX_WAYS = 16,
    parameter int L2_MAX_SETS = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_operation,
    input  logic [31:0]                i_address,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [2:0]                 o_l1_status,
    output logic [2:0]                 o_l2_status,
    input  logic                       i_cfg_we,
    input  logic [tlc_pkg::CFG_AW-1:0] i_cfg_index,
    input  logic [tlc_pkg::CFG_DW-1:0] i_cfg_data
);
    import tlc_pkg::*;

    t_cfg    r_cfg;
    t_req    w_req, w_head;
    t_q_stat w_q_stat;
    logic    w_push, w_pop, w_clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.l1_off  <= 5'd6;
            r_cfg.l1_idx  <= 4'd6;
            r_cfg.l1_ways <= 4'd4;
            r_cfg.l2_off  <= 5'd6;
            r_cfg.l2_idx  <= 4'd8;
            r_cfg.l2_ways <= 5'd8;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_L1_OFF:  r_cfg.l1_off  <= i_cfg_data;
                REG_L1_IDX:  r_cfg.l1_idx  <= i_cfg_data[3:0];
                REG_L1_WAYS: r_cfg.l1_ways <= i_cfg_data[3:0];
                REG_L2_OFF:  r_cfg.l2_off  <= i_cfg_data;
                REG_L2_IDX:  r_cfg.l2_idx  <= i_cfg_data[3:0];
                REG_L2_WAYS: r_cfg.l2_ways <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tlc_front #(
        .L1_MAX_SETS(L1_MAX_SETS),
        .L2_MAX_SETS(L2_MAX_SETS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_hold      (w_clearing),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .i_address   (i_address),
        .o_push      (w_push),
        .o_req       (w_req),
        .i_q_stat    (w_q_stat)
    );

    tlc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_req   (w_req),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    tlc_back #(
        .L1_MAX_WAYS(L1_MAX_WAYS),
        .L1_MAX_SETS(L1_MAX_SETS),
        .L2_MAX_WAYS(L2_MAX_WAYS),
        .L2_MAX_SETS(L2_MAX_SETS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_head      (w_head),
        .i_q_stat    (w_q_stat),
        .o_pop       (w_pop),
        .o_clearing  (w_clearing),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_l1_status (o_l1_status),
        .o_l2_status (o_l2_status)
    );
endmodule

// ----- hdl/tlc_checker.sv -----
// ----------------------------------------------------------------------------
// tlc_checker
// Port-level checks of the two-level cache model, bound to the top level.
// ----------------------------------------------------------------------------
`include "two_level_cache_hit_miss_model_defines.svh"

module tlc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [2:0] o_l1_status,
    input logic [2:0] o_l2_status
);
    import tlc_pkg::*;

    `TLC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `TLC_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_l1_status) && $stable(o_l2_status))
    `TLC_ASSERT_SAME(a_l2_skip, i_clk, i_rst_n, o_out_valid, (o_l2_status == ST_NONE) == ((o_l1_status == ST_RHIT) || (o_l1_status == ST_WHIT)))
    `TLC_ASSERT_SAME(a_read_miss, i_clk, i_rst_n, o_out_valid && (o_l1_status == ST_RMISS), (o_l2_status == ST_RHIT) || (o_l2_status == ST_RMISS))
    `TLC_ASSERT_SAME(a_write_miss, i_clk, i_rst_n, o_out_valid && (o_l1_status == ST_WMISS), (o_l2_status == ST_WHIT) || (o_l2_status == ST_WMISS))
endmodule

bind two_level_cache_hit_miss_model tlc_checker u_tlc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_l1_status (o_l1_status),
    .o_l2_status (o_l2_status)
);

// ----- verif/two_level_cache_hit_miss_model_tb.sv -----
// ----------------------------------------------------------------------------
// two_level_cache_hit_miss_model_tb
// Drives read and write accesses under several cache geometries, predicts the
// L1 and L2 status of each access with a local tag/valid/pointer model, and
// compares every output transfer against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_level_cache_hit_miss_model_tb;
    import tlc_pkg::*;

    localparam int L1W = 8;
    localparam int L1S = 256;
    localparam int L2W = 16;
    localparam int L2S = 1024;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_operation = 1'b0;
    logic [31:0] i_address = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_l1_status;
    logic [2:0]  o_l2_status;
    logic        i_cfg_we = 1'b0;
    logic [CFG_AW-1:0] i_cfg_index = '0;
    logic [CFG_DW-1:0] i_cfg_data = '0;

    two_level_cache_hit_miss_model dut (.*);

    always #4 i_clk = ~i_clk;

    typedef struct {
        t_status l1;
        t_status l2;
    } t_outcome;

    t_outcome status_q[$];
    int errors = 0;
    int idle_pct = 14;
    int hold_cycles = 0;

    logic [4:0] c_l1_off, c_l2_off, c_l2_ways;
    logic [3:0] c_l1_idx, c_l1_ways, c_l2_idx;

    logic [31:0] l1_tag [L1S*L1W];
    bit          l1_vld [L1S*L1W];
    int          l1_ptr [L1S];
    logic [31:0] l2_tag [L2S*L2W];
    bit          l2_vld [L2S*L2W];
    int          l2_ptr [L2S];

    function automatic int tag_of(logic [31:0] a, int off, int idx);
        return (off + idx >= 32) ? 0 : int'(a >> (off + idx));
    endfunction

    function automatic int set_of(logic [31:0] a, int off, int idx, int sets);
        logic [31:0] v;
        v = a >> off;
        v = v & ((32'd1 << idx) - 32'd1);
        return int'(v % sets);
    endfunction

    function automatic int ways_of(int w, int maxw);
        return (w == 0) ? 1 : ((w > maxw) ? maxw : w);
    endfunction

    function automatic t_outcome predict_access(logic wr, logic [31:0] a);
        t_outcome r;
        int w1, w2, s1, s2, b1, b2, p;
        logic [31:0] t1, t2;
        bit h1, h2;
        w1 = ways_of(c_l1_ways, L1W);
        w2 = ways_of(c_l2_ways, L2W);
        t1 = tag_of(a, c_l1_off, c_l1_idx);
        t2 = tag_of(a, c_l2_off, c_l2_idx);
        s1 = set_of(a, c_l1_off, c_l1_idx, L1S);
        s2 = set_of(a, c_l2_off, c_l2_idx, L2S);
        b1 = s1 * L1W;
        b2 = s2 * L2W;
        h1 = 0;
        h2 = 0;
        for (int i = 0; i < w1; i++) if (l1_vld[b1+i] && l1_tag[b1+i] == t1) h1 = 1;
        if (!h1)
            for (int i = 0; i < w2; i++) if (l2_vld[b2+i] && l2_tag[b2+i] == t2) h2 = 1;
        if (h1) begin
            r.l1 = wr ? ST_WHIT : ST_RHIT;
            r.l2 = ST_NONE;
        end else if (wr) begin
            r.l1 = ST_WMISS;
            r.l2 = h2 ? ST_WHIT : ST_WMISS;
        end else begin
            r.l1 = ST_RMISS;
            r.l2 = h2 ? ST_RHIT : ST_RMISS;
            if (!h2) begin
                p = (l2_ptr[s2] >= w2) ? 0 : l2_ptr[s2];
                l2_tag[b2+p] = t2;
                l2_vld[b2+p] = 1;
                l2_ptr[s2] = (p + 1 >= w2) ? 0 : p + 1;
            end
            p = (l1_ptr[s1] >= w1) ? 0 : l1_ptr[s1];
            l1_tag[b1+p] = t1;
            l1_vld[b1+p] = 1;
            l1_ptr[s1] = (p + 1 >= w1) ? 0 : p + 1;
        end
        return r;
    endfunction

    task automatic send_access(logic wr, logic [31:0] a);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= wr;
        i_address   <= a;
        do @(posedge i_clk); while (o_in_stall);
        status_q.push_back(predict_access(wr, a));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_AW-1:0] idx, int val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DW'(val);
        @(posedge i_clk);
        case (idx)
            REG_L1_OFF:  c_l1_off  = 5'(val);
            REG_L1_IDX:  c_l1_idx  = 4'(val);
            REG_L1_WAYS: c_l1_ways = 4'(val);
            REG_L2_OFF:  c_l2_off  = 5'(val);
            REG_L2_IDX:  c_l2_idx  = 4'(val);
            REG_L2_WAYS: c_l2_ways = 5'(val);
            default: ;
        endcase
    endtask

    task automatic set_geometry(int o1, int x1, int w1, int o2, int x2, int w2);
        drain();
        write_reg(REG_L1_OFF, o1);
        write_reg(REG_L1_IDX, x1);
        write_reg(REG_L1_WAYS, w1);
        write_reg(REG_L2_OFF, o2);
        write_reg(REG_L2_IDX, x2);
        write_reg(REG_L2_WAYS, w2);
        i_cfg_we <= 1'b0;
    endtask

    // addresses drawn from a small pool of blocks so hits and evictions occur
    function automatic logic [31:0] pool_addr(int nblk);
        logic [31:0] a;
        a = $urandom_range(nblk - 1);
        a = (a << 6) ^ ((a & 32'h7) << 20) ^ ($urandom_range(63));
        if ($urandom_range(15) == 0) a = $urandom;
        return a;
    endfunction

    task automatic test_directed();
        send_access(1'b0, 32'h0000_0000);
        send_access(1'b0, 32'h0000_0000);
        send_access(1'b1, 32'h0000_0000);
        send_access(1'b1, 32'hFFFF_FFFF);
        send_access(1'b0, 32'hFFFF_FFFF);
        send_access(1'b0, 32'hFFFF_FFC0);
        send_access(1'b1, 32'hFFFF_FFFF);
        for (int i = 0; i < 6; i++) send_access(1'b0, 32'h0001_0000 * i + 32'h40);
        send_access(1'b1, 32'h0001_0040);
        send_access(1'b0, 32'h0001_0040);
        send_access(1'b0, 32'hAAAA_5555);
        send_access(1'b0, 32'h5555_AAAA);
        send_access(1'b1, 32'h5555_AAAA);
    endtask

    task automatic test_random(int n, int nblk);
        for (int i = 0; i < n; i++) send_access($urandom_range(3) == 0, pool_addr(nblk));
    endtask

    task automatic test_geometry_extremes();
        // fully associative both levels, offsets of 16
        set_geometry(16, 0, 8, 16, 0, 16);
        test_random(150, 40);
        // zero L1 offset, L1 index 8 and L2 index 15, zero ways, a one-bit tag at L2
        set_geometry(0, 8, 0, 16, 15, 0);
        test_random(150, 60);
        // out-of-range ways and tag shifts of 32 bits or more; stale pointers from earlier fills
        set_geometry(31, 15, 15, 31, 15, 31);
        test_random(100, 30);
        set_geometry(6, 2, 3, 6, 3, 5);
        test_random(250, 60);
        set_geometry(3, 1, 1, 4, 10, 1);
        test_random(150, 50);
    endtask

    task automatic test_backpressure();
        idle_pct = 0;
        hold_cycles = 60;
        test_random(100, 50);
        idle_pct = 14;
    endtask

    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_out_stall <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (status_q.size() == 0) begin
                $display("%0t: unexpected transfer l1=%0d l2=%0d", $time, o_l1_status,
                         o_l2_status);
                errors++;
            end else begin
                if (o_l1_status !== status_q[0].l1 || o_l2_status !== status_q[0].l2) begin
                    $display("%0t: expected l1=%0d l2=%0d actual l1=%0d l2=%0d", $time,
                             status_q[0].l1, status_q[0].l2, o_l1_status, o_l2_status);
                    errors++;
                end
                void'(status_q.pop_front());
            end
        end
    end

    initial begin
        #5000000;
        $display("two_level_cache_hit_miss_model_tb failed");
        $finish;
    end

    initial begin
        c_l1_off = 6; c_l1_idx = 6; c_l1_ways = 4;
        c_l2_off = 6; c_l2_idx = 8; c_l2_ways = 8;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(300, 400);
        idle_pct = 0;
        test_random(150, 200);
        idle_pct = 14;
        test_geometry_extremes();
        test_backpressure();
        set_geometry(6, 6, 4, 6, 8, 8);
        test_random(382, 300);
        drain();
        if (errors == 0 && status_q.size() == 0)
            $display("two_level_cache_hit_miss_model_tb passed");
        else
            $display("two_level_cache_hit_miss_model_tb failed");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+hdl
hdl/tlc_pkg.sv
hdl/tlc_queue.sv
hdl/tlc_front.sv
hdl/tlc_back.sv
hdl/two_level_cache_hit_miss_model.sv
hdl/tlc_checker.sv
verif/two_level_cache_hit_miss_model_tb.sv
